[sv/sdq_pkg.sv]
package sdq_pkg;

   localparam int SDQ_DEPTH     = 16;
   localparam int SDQ_ID_BITS   = 8;
   localparam int SDQ_TIME_BITS = 16;

   // releases allowed per tick
   localparam int MAX_OUT = 16;

   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;

   localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_TICK   = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_POP    = 2'd2;

   localparam logic [STATUS_BITS-1:0] ST_RELEASE   = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_POPPED    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_POP_EMPTY = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_INSERTED  = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_REJECTED  = 3'd4;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INS_RD,
      S_INS_CMP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_TICK_CHK,
      S_POP_CHK,
      S_POP_ADD,
      S_EMIT
   } state_type;

endpackage

[sv/sleep_delta_queue_top.sv]
// channel  | handshake                | payload
// req      | req_valid / req_stall    | req_cmd, req_proc_id, req_wait_ticks
// rsp      | rsp_valid / rsp_stall    | rsp_out_proc, rsp_status, rsp_last
//
// one request at a time; the entry memory has a single read and a single write port
// insert: compares entries from the head, then moves the later ones back a place
// tick: releases expired entries, up to MAX_OUT; pop: removes the head entry
// reset is synchronous; it clears occupancy, head pointer and control, memory stays
// a stalled result holds the sequencer until the output register frees up
module sleep_delta_queue_top
   import sdq_pkg::*;
#(
   parameter int DEPTH     = SDQ_DEPTH,
   parameter int ID_BITS   = SDQ_ID_BITS,
   parameter int TIME_BITS = SDQ_TIME_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CMD_BITS-1:0]    req_cmd,
   input  logic [ID_BITS-1:0]     req_proc_id,
   input  logic [TIME_BITS-1:0]   req_wait_ticks,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [ID_BITS-1:0]     rsp_out_proc,
   output logic [STATUS_BITS-1:0] rsp_status,
   output logic                   rsp_last
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int OW = AW + 1;
   localparam int DW = TIME_BITS + 2;
   localparam int NW = $clog2(MAX_OUT + 1);
   localparam logic [OW-1:0] DEPTH_W = OW'(DEPTH);
   localparam logic [NW-1:0] MAX_W   = NW'(MAX_OUT);

   typedef struct packed {
      logic [ID_BITS-1:0]   proc;
      logic signed [DW-1:0] delta;
   } entry_type;

   // entry memory, circular with head pointer
   entry_type mem [DEPTH];
   entry_type rd_data_ff;
   entry_type wr_data;
   logic          rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;

   state_type state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [OW-1:0] pos_ff, pos_in;
   logic [OW-1:0] idx_ff, idx_in;
   logic [NW-1:0] n_ff, n_in;
   logic signed [DW-1:0] w_ff, w_in;
   logic signed [DW-1:0] acc_ff, acc_in;
   logic [ID_BITS-1:0]     res_proc_ff, res_proc_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;

   logic                   rsp_valid_ff;
   logic [ID_BITS-1:0]     rsp_proc_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic                   rsp_last_ff;
   logic                   out_load, out_last;
   logic [ID_BITS-1:0]     out_proc;
   logic [STATUS_BITS-1:0] out_status;

   logic accept, out_free, ins_le, tick_rel, tick_go;
   logic signed [DW-1:0] d, tick_acc;
   logic [AW-1:0] next_head;

   // logical position to memory address
   function automatic logic [AW-1:0] phys(input logic [AW-1:0] h, input logic [OW-1:0] i);
      logic [OW-1:0] s;
      s = OW'(h) + i;
      if (s >= DEPTH_W) begin
         s = s - DEPTH_W;
      end
      return s[AW-1:0];
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign d         = rd_data_ff.delta;
   assign ins_le    = (d <= w_ff);
   // first pass of a tick takes the tick off, later passes carry the remainder
   assign tick_acc  = (n_ff == '0) ? (d - DW'(1)) : (d + acc_ff);
   assign tick_rel  = (tick_acc[DW-1] || tick_acc == '0) && (n_ff < MAX_W);
   assign tick_go   = (n_ff == '0) || out_free;
   assign next_head = phys(head_ff, OW'(1));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_INSERT: state_in = (occ_ff == DEPTH_W) ? S_EMIT : S_INS_RD;
                  CMD_TICK:   state_in = (occ_ff == '0) ? S_IDLE : S_TICK_CHK;
                  CMD_POP:    state_in = (occ_ff == '0) ? S_EMIT : S_POP_CHK;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_INS_RD:   state_in = (pos_ff < occ_ff) ? S_INS_CMP : S_SHIFT_RD;
         S_INS_CMP:  state_in = ins_le ? S_INS_RD : S_SHIFT_RD;
         S_SHIFT_RD: state_in = (idx_ff == pos_ff) ? S_EMIT : S_SHIFT_WR;
         S_SHIFT_WR: state_in = S_SHIFT_RD;
         S_TICK_CHK: begin
            if (tick_go) begin
               if (tick_rel) begin
                  state_in = (occ_ff > OW'(1)) ? S_TICK_CHK : S_EMIT;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_POP_CHK:  state_in = (occ_ff > OW'(1)) ? S_POP_ADD : S_EMIT;
         S_POP_ADD:  state_in = S_EMIT;
         S_EMIT:     state_in = out_free ? S_IDLE : S_EMIT;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      head_in       = head_ff;
      occ_in        = occ_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      n_in          = n_ff;
      w_in          = w_ff;
      acc_in        = acc_ff;
      res_proc_in   = res_proc_ff;
      res_status_in = res_status_ff;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_data       = rd_data_ff;
      out_load      = 1'b0;
      out_last      = 1'b1;
      out_proc      = res_proc_ff;
      out_status    = res_status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_proc_in = req_proc_id;
               w_in        = DW'(req_wait_ticks);
               pos_in      = '0;
               n_in        = '0;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     res_status_in = (occ_ff == DEPTH_W) ? ST_REJECTED : ST_INSERTED;
                  end
                  CMD_TICK: begin
                     rd_en = 1'b1;
                  end
                  CMD_POP: begin
                     rd_en = 1'b1;
                     if (occ_ff == '0) begin
                        res_status_in = ST_POP_EMPTY;
                        res_proc_in   = '0;
                     end else begin
                        res_status_in = ST_POPPED;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_INS_RD: begin
            if (pos_ff < occ_ff) begin
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, pos_ff);
            end else begin
               idx_in = occ_ff;
            end
         end
         S_INS_CMP: begin
            if (ins_le) begin
               w_in   = w_ff - d;
               pos_in = pos_ff + OW'(1);
            end else begin
               idx_in = occ_ff;
            end
         end
         S_SHIFT_RD: begin
            if (idx_ff == pos_ff) begin
               wr_en         = 1'b1;
               wr_addr       = phys(head_ff, pos_ff);
               wr_data.proc  = res_proc_ff;
               wr_data.delta = w_ff;
               occ_in        = occ_ff + OW'(1);
            end else begin
               rd_en   = 1'b1;
               rd_addr = phys(head_ff, idx_ff - OW'(1));
            end
         end
         S_SHIFT_WR: begin
            // the entry just behind the new one gives up the new wait
            wr_en         = 1'b1;
            wr_addr       = phys(head_ff, idx_ff);
            wr_data.proc  = rd_data_ff.proc;
            wr_data.delta = ((idx_ff - OW'(1)) == pos_ff) ? (d - w_ff) : d;
            idx_in        = idx_ff - OW'(1);
         end
         S_TICK_CHK: begin
            if (tick_go) begin
               if (n_ff != '0) begin
                  out_load   = 1'b1;
                  out_proc   = res_proc_ff;
                  out_status = ST_RELEASE;
                  out_last   = !tick_rel;
               end
               if (tick_rel) begin
                  res_proc_in   = rd_data_ff.proc;
                  res_status_in = ST_RELEASE;
                  acc_in        = tick_acc;
                  n_in          = n_ff + NW'(1);
                  head_in       = next_head;
                  occ_in        = occ_ff - OW'(1);
                  rd_en         = (occ_ff > OW'(1));
                  rd_addr       = next_head;
               end else begin
                  wr_en         = 1'b1;
                  wr_addr       = head_ff;
                  wr_data.proc  = rd_data_ff.proc;
                  wr_data.delta = tick_acc;
               end
            end
         end
         S_POP_CHK: begin
            res_proc_in = rd_data_ff.proc;
            acc_in      = d;
            head_in     = next_head;
            occ_in      = occ_ff - OW'(1);
            rd_en       = (occ_ff > OW'(1));
            rd_addr     = next_head;
         end
         S_POP_ADD: begin
            wr_en         = 1'b1;
            wr_addr       = head_ff;
            wr_data.proc  = rd_data_ff.proc;
            wr_data.delta = d + acc_ff;
         end
         S_EMIT: begin
            out_load = out_free;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         occ_ff   <= occ_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      idx_ff        <= idx_in;
      n_ff          <= n_in;
      w_ff          <= w_in;
      acc_ff        <= acc_in;
      res_proc_ff   <= res_proc_in;
      res_status_ff <= res_status_in;
      if (out_load) begin
         rsp_proc_ff   <= out_proc;
         rsp_status_ff <= out_status;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_proc = rsp_proc_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_last     = rsp_last_ff;

`ifndef SYNTHESIS
   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= DEPTH_W) else $error("occupancy beyond depth");
   a_load_free: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free) else $error("result overwrote a waiting one");
   a_tick_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_TICK_CHK |-> n_ff <= MAX_W) else $error("too many releases");
   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> rd_addr != wr_addr) else $error("read and write same entry");
`endif

endmodule
